// ===== hw/rtl/dqr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqr_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = IDX_W + 1;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_BWD   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DATA = 1'b1
  } state_e;

endpackage : dqr_pkg

`default_nettype wire

// ===== hw/rtl/double_ended_queue_ring_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   opcode_i, value_i
// result    out        out_valid_o / out_stall_i status_o, data_o, last_of_run_o
//
// Pushes, failed operations and unknown opcodes are answered from idle with a registered result.
// Pops go through the data state: the store has one read port, and its read is registered.
// A dump of N elements fetches through that same read port and then gives one result
// per cycle while the result is not stalled.
// Reset clears head, count, control and output valid; the store is not cleared.
// A stalled result holds; a request is taken while a result still waits only
// once that result is being taken.

module double_ended_queue_ring_unit
  import dqr_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  [2:0]              opcode_i,
  input  wire  signed [DATA_W-1:0] value_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                    last_of_run_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             is_dump_q, is_dump_d;
  logic             back_q, back_d;

  logic                     out_valid_q;
  logic [1:0]               out_status_q, out_status_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;
  logic                     load_out;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  logic out_free, accept, run_last;
  logic [CNT_W-1:0] next_off;

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == FSM_IDLE) && out_free);
  assign accept = in_valid_i && !in_stall_o;
  assign run_last = !is_dump_q || ((idx_q + CNT_W'(1)) == count_q);
  assign next_off = back_q ? (count_q - CNT_W'(2) - idx_q) : (idx_q + CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && rd_en) begin
          state_d = FSM_DATA;
        end
      end
      FSM_DATA: begin
        if (out_free && run_last) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Store accesses, pointer updates and result loading.
  // Writes happen only on an accepted push in idle, and reads only on an
  // accepted pop or dump or during the data phase, so no entry is read and
  // written in overlapping cycles.
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    is_dump_d    = is_dump_q;
    back_d       = back_q;
    wr_en        = 1'b0;
    wr_addr      = head_q;
    rd_en        = 1'b0;
    rd_addr      = head_q;
    load_out     = 1'b0;
    out_status_d = ST_OK;
    out_data_d   = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (opcode_i) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (opcode_i == OP_PUSH_BACK) begin
                  wr_addr = ring_pos(head_q, count_q);
                end else begin
                  wr_addr = ring_pos(head_q, CNT_W'(DEPTH - 1));
                  head_d  = wr_addr;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                // result comes from the store next cycle
                load_out  = 1'b0;
                rd_en     = 1'b1;
                idx_d     = '0;
                is_dump_d = (opcode_i == OP_DUMP_FWD) || (opcode_i == OP_DUMP_BWD);
                back_d    = (opcode_i == OP_POP_BACK) || (opcode_i == OP_DUMP_BWD);
                if (back_d) begin
                  rd_addr = ring_pos(head_q, count_q - CNT_W'(1));
                end
                if (!is_dump_d) begin
                  count_d = count_q - CNT_W'(1);
                  if (!back_d) begin
                    head_d = ring_pos(head_q, CNT_W'(1));
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      FSM_DATA: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_data_d = rd_data_q;
          out_last_d = run_last;
          if (!run_last) begin
            // advance the dump and fetch the next element
            idx_d   = idx_q + CNT_W'(1);
            rd_en   = 1'b1;
            rd_addr = ring_pos(head_q, next_off);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      is_dump_q   <= 1'b0;
      back_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      is_dump_q <= is_dump_d;
      back_q    <= back_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign data_o        = out_data_q;
  assign last_of_run_o = out_last_q;

endmodule : double_ended_queue_ring_unit

`default_nettype wire

// ===== hw/rtl/dqr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqr_checker
  import dqr_pkg::*;
(
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_stall_o,
  input wire  [2:0]               opcode_i,
  input wire  signed [DATA_W-1:0] value_i,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire  [1:0]               status_o,
  input wire  signed [DATA_W-1:0] data_o,
  input wire                      last_of_run_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(data_o)
      && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY || status_o == ST_FULL)
      |-> data_o == '0 && last_of_run_o)
    else $error("error result carries data or is not last");

  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> status_o == ST_OK)
    else $error("non-final result without ok status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_FULL)
    else $error("undefined status code");

endmodule : dqr_checker

bind double_ended_queue_ring_unit dqr_checker u_dqr_checker (.*);

`default_nettype wire

// ===== verif/double_ended_queue_ring_unit_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_ring_unit_tb;
  import dqr_pkg::*;

  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int unsigned RANDOM_REQS = 80;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  typedef struct {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } deque_req_t;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } deque_res_t;

  logic                     clk_i;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic [2:0]               opcode = OP_PUSH_BACK;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_stall = 1'b0;
  wire                      in_stall;
  wire                      out_valid;
  wire  [1:0]               status;
  wire  signed [DATA_W-1:0] data;
  wire                      last_of_run;

  // shadow copy of the ring
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned       front_idx = 0;
  int unsigned       fill_cnt = 0;

  deque_req_t  req_pending [$];
  deque_res_t  owed_results [$];
  int unsigned mismatches = 0;
  int unsigned req_taken = 0;
  int unsigned res_taken = 0;
  int unsigned cycle_cnt = 0;

  // driver-side bookkeeping, written at the falling edge only
  deque_req_t  req_cur;
  logic        req_busy = 1'b0;
  int unsigned req_sent = 0;
  int unsigned gap_left = 0;
  int unsigned in_quiet = 0;
  int unsigned res_seen = 0;
  int unsigned hold_left = 0;
  int unsigned out_quiet = 0;

  double_ended_queue_ring_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .data_o        (data),
    .last_of_run_o (last_of_run)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  task automatic owe(input status_e st, input logic [DATA_W-1:0] d, input logic lst);
    deque_res_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    owed_results.push_back(r);
  endtask

  // Work out the results of one request and update the shadow ring.
  task automatic apply_deque_op(input logic [2:0] op, input logic [DATA_W-1:0] val);
    int unsigned off;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (fill_cnt >= DEPTH) begin
          owe(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_PUSH_BACK) begin
            ring_mem[(front_idx + fill_cnt) % DEPTH] = val;
          end else begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            ring_mem[front_idx] = val;
          end
          fill_cnt++;
          owe(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_cnt == 0) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else if (op == OP_POP_FRONT) begin
          owe(ST_OK, ring_mem[front_idx], 1'b1);
          front_idx = (front_idx + 1) % DEPTH;
          fill_cnt--;
        end else begin
          owe(ST_OK, ring_mem[(front_idx + fill_cnt - 1) % DEPTH], 1'b1);
          fill_cnt--;
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        if (fill_cnt == 0) owe(ST_EMPTY, '0, 1'b1);
        for (int unsigned i = 0; i < fill_cnt; i++) begin
          off = (op == OP_DUMP_FWD) ? i : fill_cnt - 1 - i;
          owe(ST_OK, ring_mem[(front_idx + off) % DEPTH], i + 1 == fill_cnt);
        end
      end
      default: owe(ST_OK, '0, 1'b1);
    endcase
  endtask

  // Per-item wait, with the odd stretch of back-to-back traffic.
  function automatic int unsigned draw_idle(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) quiet = $urandom_range(8, 24);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic signed [DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // lean: chance in percent that a push/pop slot becomes a push
  function automatic deque_req_t rand_req(input int unsigned lean);
    deque_req_t  r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.value = ($urandom_range(0, 7) == 0) ? extreme_value() : $urandom;
    if (roll < 3)
      r.opcode = roll[0] ? OP_RSVD_7 : OP_RSVD_6;
    else if (roll < 11)
      r.opcode = roll[0] ? OP_DUMP_FWD : OP_DUMP_BWD;
    else if ($urandom_range(0, 99) < lean)
      r.opcode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else
      r.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    return r;
  endfunction

  task automatic add_req(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
    deque_req_t r;
    r.opcode = op;
    r.value  = val;
    req_pending.push_back(r);
  endtask

  always @(negedge clk_i) begin : drive_requests
    if (rst_n) begin
      if (req_busy && req_taken != req_sent) begin
        req_sent++;
        req_busy = 1'b0;
      end
      if (!req_busy && req_pending.size() > 0) begin
        if (gap_left == 0) begin
          req_cur  = req_pending.pop_front();
          req_busy = 1'b1;
          gap_left = draw_idle(in_quiet);
        end else begin
          gap_left--;
        end
      end
      in_valid <= req_busy;
      if (req_busy) begin
        opcode <= req_cur.opcode;
        value  <= req_cur.value;
      end
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (res_taken != res_seen) begin
      res_seen  = res_taken;
      hold_left = draw_idle(out_quiet);
    end
    if (out_valid === 1'b1 && hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    deque_res_t w;
    if (rst_n) begin
      // check results before taking the new request: results are never same-cycle
      if (out_valid === 1'b1 && !out_stall) begin
        res_taken <= res_taken + 1;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d data %h", status, data));
        end else begin
          w = owed_results.pop_front();
          check_field("status", 32'(status), 32'(w.status));
          check_field("data", data, w.data);
          check_field("last_of_run", 32'(last_of_run), 32'(w.last));
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        req_taken <= req_taken + 1;
        apply_deque_op(opcode, value);
      end
    end
  end

  initial begin : time_guard
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_sequence
    int unsigned n;
    int unsigned len;
    int unsigned lean;

    // empty queue: every pop and dump flags empty
    add_req(OP_POP_FRONT, 32'sh1234_5678);
    add_req(OP_POP_BACK, '1);
    add_req(OP_DUMP_FWD, '0);
    add_req(OP_DUMP_BWD, 32'sh8000_0000);
    // fill to the brim from both ends
    for (int i = 0; i < DEPTH; i++) begin
      add_req((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
              (i < 4) ? extreme_value() : $urandom);
    end
    add_req(OP_PUSH_BACK, 32'sh7fff_ffff);
    add_req(OP_PUSH_FRONT, 32'sh8000_0000);
    add_req(OP_DUMP_FWD, '0);
    add_req(OP_DUMP_BWD, '0);
    add_req(OP_POP_FRONT, '0);
    add_req(OP_POP_BACK, '0);
    add_req(OP_RSVD_6, '1);
    add_req(OP_RSVD_7, 32'sh5555_aaaa);

    // runs that lean towards filling, draining or neither
    n = 0;
    while (n < RANDOM_REQS) begin
      len = $urandom_range(6, 16);
      case ($urandom_range(0, 2))
        0:       lean = 75;
        1:       lean = 25;
        default: lean = 50;
      endcase
      repeat (len) req_pending.push_back(rand_req(lean));
      n += len;
    end

    @(posedge rst_n);
    while (req_pending.size() != 0 || req_busy || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
